// File: hw/rtl/pffa_pkg.sv
// package for the partition first-fit allocator
// types and constants shared by all rtl files, no dependencies
package pffa_pkg;
    localparam int NumParts   = 16;
    localparam int QueueDepth = 16;
    localparam int PartIdxW   = $clog2(NumParts);
    localparam int QueueIdxW  = $clog2(QueueDepth);
    localparam int PartCntW   = $clog2(NumParts + 1);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);
    localparam logic [15:0] DefaultMemory = 16'd40;

    localparam logic [1:0] StatusPlaced  = 2'd0;
    localparam logic [1:0] StatusQueued  = 2'd1;
    localparam logic [1:0] StatusDropped = 2'd2;

    localparam logic ModeSubmit = 1'b0;
    localparam logic ModeTick   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  proc_id;
        logic [15:0] proc_size;
        logic [15:0] run_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        done_valid;
        logic [7:0]  done_id;
        logic [4:0]  placed_count;
        logic [15:0] free_memory;
        logic [4:0]  waiting_count;
        logic        all_idle;
    } rsp_t;

    // shared comparator request and answer
    typedef struct packed {
        logic [15:0] lhs;
        logic [15:0] rhs;
    } cmp_req_t;

    typedef struct packed {
        logic ge;
        logic eq;
    } cmp_rsp_t;
endpackage

// File: hw/rtl/pffa_if.sv
// valid/ready channel interfaces for requests and responses
// depends on pffa_pkg
interface pffa_req_if import pffa_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pffa_rsp_if import pffa_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pffa_cmp.sv
// shared 16-bit compare unit used by the sequencer in its submit, countdown and fill evaluate states
// depends on pffa_pkg
module pffa_cmp import pffa_pkg::*; (
    input  cmp_req_t req,
    output cmp_rsp_t rsp
);
    // unsigned greater-or-equal and equality test
    assign rsp.ge = req.lhs >= req.rhs;
    assign rsp.eq = req.lhs == req.rhs;
endmodule

// File: hw/rtl/partition_first_fit_allocator.sv
// submit: intake, then one placement decision in S_SUB, then the result is offered; tick: a
// read/eval pair per partition scanned, then per partition a fill read, plus for a free one a
// read/eval pair per queue entry tried and a read/write pair per entry moved
// one transaction in flight, next intake in the cycle after the result is taken; the sequencer
// walks one partition or queue entry at a time through the shared compare unit
// asynchronous active-low reset clears control state; table and queue entries hold no valid bits
module partition_first_fit_allocator import pffa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    pffa_req_if.sink     in_ch,
    pffa_rsp_if.source   out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_SUB, S_T_RD, S_T_EV, S_F_RD, S_F_QRD, S_F_QEV, S_SH_RD, S_SH_WR,
        S_OUT
    } state_t;

    // partition and queue stores
    logic [15:0] p_size [NumParts];
    logic [7:0]  p_owner [NumParts];
    logic [15:0] p_osize [NumParts];
    logic [15:0] p_time [NumParts];
    logic [NumParts-1:0] p_busy_reg;
    logic [7:0]  q_id [QueueDepth];
    logic [15:0] q_size [QueueDepth];
    logic [15:0] q_time [QueueDepth];

    state_t state_reg;
    req_t   req_reg;
    logic [1:0]           status_reg;
    logic [PartCntW-1:0]  pcount_reg;
    logic [QueueCntW-1:0] qcount_reg;
    logic [15:0]          free_reg;
    logic                 closed_reg;
    logic [PartCntW-1:0]  pi_reg;
    logic [QueueCntW-1:0] qj_reg;
    logic [4:0]           placed_reg;
    logic                 done_reg;
    logic [7:0]           done_id_reg;
    // registered reads
    logic [15:0] rd_size_reg, rd_time_reg, rd_osize_reg, rq_size_reg;
    logic [7:0]  rd_owner_reg;

    cmp_req_t cmp_req;
    cmp_rsp_t cmp_rsp;
    pffa_cmp u_cmp (.req(cmp_req), .rsp(cmp_rsp));

    logic [PartIdxW-1:0]  pidx;
    logic [QueueIdxW-1:0] qidx;
    logic [PartIdxW-1:0]  pcidx;
    logic [QueueIdxW-1:0] qcidx;
    logic [QueueIdxW-1:0] qnext;
    logic [16:0]          free_sum;
    assign pidx  = pi_reg[PartIdxW-1:0];
    assign qidx  = qj_reg[QueueIdxW-1:0];
    assign pcidx = pcount_reg[PartIdxW-1:0];
    assign qcidx = qcount_reg[QueueIdxW-1:0];
    assign qnext = qidx + QueueIdxW'(1);
    assign free_sum = {1'b0, free_reg} + {1'b0, rd_osize_reg};

    // comparator operand select by state
    always_comb
    begin
        cmp_req = '0;
        unique case (state_reg)
            S_SUB:   cmp_req = '{lhs: free_reg, rhs: req_reg.proc_size};
            S_T_EV:  cmp_req = '{lhs: rd_time_reg, rhs: 16'd0};
            S_F_QEV: cmp_req = '{lhs: rd_size_reg, rhs: rq_size_reg};
            default: cmp_req = '0;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);

    // response built from the settled state, which holds while the result waits unless cfg_we rewrites free memory
    assign out_ch.data = '{
        status:        status_reg,
        done_valid:    done_reg,
        done_id:       done_id_reg,
        placed_count:  placed_reg,
        free_memory:   free_reg,
        waiting_count: 5'(qcount_reg),
        all_idle:      (p_busy_reg == '0)
    };

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        rd_size_reg  <= p_size[pidx];
        rd_time_reg  <= p_time[pidx];
        rd_osize_reg <= p_osize[pidx];
        rd_owner_reg <= p_owner[pidx];
        rq_size_reg  <= q_size[qidx];
        if (state_reg == S_SUB && !closed_reg && cmp_rsp.ge
            && (pcount_reg + PartCntW'(1) < PartCntW'(NumParts)))
        begin
            p_size[pcidx]  <= req_reg.proc_size;
            p_owner[pcidx] <= req_reg.proc_id;
            p_osize[pcidx] <= req_reg.proc_size;
            p_time[pcidx]  <= req_reg.run_time;
        end
        else if (state_reg == S_SUB && !closed_reg && qcount_reg < QueueCntW'(QueueDepth))
        begin
            p_size[pcidx] <= free_reg;
        end
        if (state_reg == S_SUB && qcount_reg < QueueCntW'(QueueDepth))
        begin
            q_id[qcidx]   <= req_reg.proc_id;
            q_size[qcidx] <= req_reg.proc_size;
            q_time[qcidx] <= req_reg.run_time;
        end
        if (state_reg == S_T_EV && !cmp_rsp.eq && p_busy_reg[pidx])
            p_time[pidx] <= rd_time_reg - 16'd1;
        if (state_reg == S_F_QEV && cmp_rsp.ge)
        begin
            p_owner[pidx] <= q_id[qidx];
            p_osize[pidx] <= q_size[qidx];
            p_time[pidx]  <= q_time[qidx];
        end
        if (state_reg == S_SH_WR)
        begin
            q_id[qidx]   <= q_id[qnext];
            q_size[qidx] <= q_size[qnext];
            q_time[qidx] <= q_time[qnext];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            p_busy_reg  <= '0;
            pcount_reg  <= '0;
            qcount_reg  <= '0;
            free_reg    <= DefaultMemory;
            closed_reg  <= 1'b0;
            pi_reg      <= '0;
            qj_reg      <= '0;
            placed_reg  <= '0;
            done_reg    <= 1'b0;
            done_id_reg <= '0;
            status_reg  <= StatusPlaced;
            req_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                free_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        req_reg    <= in_ch.data;
                        pi_reg     <= '0;
                        qj_reg     <= '0;
                        placed_reg <= '0;
                        done_reg   <= 1'b0;
                        done_id_reg <= '0;
                        status_reg <= StatusPlaced;
                        state_reg  <= (in_ch.data.mode == ModeSubmit) ? S_SUB : S_T_RD;
                    end
                end
                S_SUB:
                begin
                    if (closed_reg)
                    begin
                        if (qcount_reg < QueueCntW'(QueueDepth))
                        begin
                            qcount_reg <= qcount_reg + QueueCntW'(1);
                            status_reg <= StatusQueued;
                        end
                        else
                            status_reg <= StatusDropped;
                    end
                    else if (cmp_rsp.ge && (pcount_reg + PartCntW'(1) < PartCntW'(NumParts)))
                    begin
                        p_busy_reg[pcidx] <= 1'b1;
                        pcount_reg <= pcount_reg + PartCntW'(1);
                        free_reg   <= free_reg - req_reg.proc_size;
                        status_reg <= StatusPlaced;
                    end
                    else if (qcount_reg < QueueCntW'(QueueDepth))
                    begin
                        p_busy_reg[pcidx] <= 1'b0;
                        pcount_reg <= pcount_reg + PartCntW'(1);
                        closed_reg <= 1'b1;
                        qcount_reg <= qcount_reg + QueueCntW'(1);
                        status_reg <= StatusQueued;
                    end
                    else
                        status_reg <= StatusDropped;
                    state_reg <= S_OUT;
                end
                // countdown scan, one partition per read/eval pair
                S_T_RD:
                begin
                    if (pi_reg >= pcount_reg)
                    begin
                        pi_reg    <= '0;
                        state_reg <= S_F_RD;
                    end
                    else
                        state_reg <= S_T_EV;
                end
                S_T_EV:
                begin
                    if (p_busy_reg[pidx] && cmp_rsp.eq)
                    begin
                        free_reg <= free_sum[16] ? 16'hFFFF : free_sum[15:0];
                        p_busy_reg[pidx] <= 1'b0;
                        done_reg    <= 1'b1;
                        done_id_reg <= rd_owner_reg;
                        pi_reg      <= '0;
                        state_reg   <= S_F_RD;
                    end
                    else
                    begin
                        pi_reg    <= pi_reg + PartCntW'(1);
                        state_reg <= S_T_RD;
                    end
                end
                // fill free partitions from the queue
                S_F_RD:
                begin
                    qj_reg <= '0;
                    if (pi_reg >= pcount_reg || qcount_reg == '0)
                        state_reg <= S_OUT;
                    else if (p_busy_reg[pidx])
                        pi_reg <= pi_reg + PartCntW'(1);
                    else
                        state_reg <= S_F_QRD;
                end
                S_F_QRD:
                begin
                    if (qj_reg >= qcount_reg)
                    begin
                        pi_reg    <= pi_reg + PartCntW'(1);
                        state_reg <= S_F_RD;
                    end
                    else
                        state_reg <= S_F_QEV;
                end
                S_F_QEV:
                begin
                    if (cmp_rsp.ge)
                    begin
                        p_busy_reg[pidx] <= 1'b1;
                        placed_reg <= placed_reg + 5'd1;
                        state_reg  <= S_SH_RD;
                    end
                    else
                    begin
                        qj_reg    <= qj_reg + QueueCntW'(1);
                        state_reg <= S_F_QRD;
                    end
                end
                // close the queue behind the taken entry
                S_SH_RD:
                begin
                    if (qj_reg + QueueCntW'(1) < qcount_reg)
                        state_reg <= S_SH_WR;
                    else
                    begin
                        qcount_reg <= qcount_reg - QueueCntW'(1);
                        pi_reg     <= pi_reg + PartCntW'(1);
                        state_reg  <= S_F_RD;
                    end
                end
                S_SH_WR:
                begin
                    qj_reg    <= qj_reg + QueueCntW'(1);
                    state_reg <= S_SH_RD;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/pffa_checker.sv
// port-level checker for the allocator, bound to the top level
// depends on pffa_pkg and the channel interfaces
module pffa_checker import pffa_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);
    // one transaction in flight: no intake while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("intake while result pending");
    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed under stall");
    // status is never the unused code
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("bad status");
    // done id is zero without a completion
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_valid |-> out_data.done_id == 8'd0)
        else $error("stray done id");
endmodule

bind partition_first_fit_allocator pffa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: test/pffa_alloc_checker.sv
// checker for the partition first-fit allocator: predicts and compares responses
// depends on pffa_pkg
module pffa_alloc_checker import pffa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_t        rsp_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // allocator shadow state
    logic [15:0] p_size  [NumParts];
    logic        p_busy  [NumParts];
    logic [7:0]  p_owner [NumParts];
    logic [15:0] p_osize [NumParts];
    logic [15:0] p_tleft [NumParts];
    int          p_cnt;
    logic [7:0]  q_id    [QueueDepth];
    logic [15:0] q_size  [QueueDepth];
    logic [15:0] q_time  [QueueDepth];
    int          q_cnt;
    logic [16:0] free_units;
    logic        closed;
    rsp_t        expected_rsp_q[$];

    function automatic logic try_enqueue(input req_t r);
        if (q_cnt >= QueueDepth)
            return 1'b0;
        q_id[q_cnt] = r.proc_id;
        q_size[q_cnt] = r.proc_size;
        q_time[q_cnt] = r.run_time;
        q_cnt++;
        return 1'b1;
    endfunction

    // compute the response for one request and advance the shadow state
    function automatic rsp_t predict_alloc(input req_t r);
        rsp_t o;
        int   i;
        int   j;
        int   k;
        o = '0;
        if (r.mode == ModeSubmit) begin
            if (closed)
                o.status = try_enqueue(r) ? StatusQueued : StatusDropped;
            else if (free_units >= r.proc_size && p_cnt + 1 < NumParts) begin
                p_size[p_cnt] = r.proc_size;
                p_busy[p_cnt] = 1'b1;
                p_owner[p_cnt] = r.proc_id;
                p_osize[p_cnt] = r.proc_size;
                p_tleft[p_cnt] = r.run_time;
                p_cnt++;
                free_units = free_units - r.proc_size;
                o.status = StatusPlaced;
            end
            else if (q_cnt >= QueueDepth)
                o.status = StatusDropped;
            else begin
                p_size[p_cnt] = free_units[15:0];
                p_busy[p_cnt] = 1'b0;
                p_cnt++;
                closed = 1'b1;
                void'(try_enqueue(r));
                o.status = StatusQueued;
            end
        end
        else begin
            // release the first expired partition, counting down those before it
            for (i = 0; i < p_cnt; i++) begin
                if (p_busy[i]) begin
                    if (p_tleft[i] == 0) begin
                        free_units = free_units + p_osize[i];
                        if (free_units > 17'hFFFF)
                            free_units = 17'hFFFF;
                        p_busy[i] = 1'b0;
                        o.done_valid = 1'b1;
                        o.done_id = p_owner[i];
                        break;
                    end
                    p_tleft[i] = p_tleft[i] - 16'd1;
                end
            end
            // first fit from the wait queue into free partitions
            for (i = 0; i < p_cnt && q_cnt > 0; i++) begin
                if (!p_busy[i]) begin
                    for (j = 0; j < q_cnt; j++) begin
                        if (p_size[i] >= q_size[j]) begin
                            p_busy[i] = 1'b1;
                            p_owner[i] = q_id[j];
                            p_osize[i] = q_size[j];
                            p_tleft[i] = q_time[j];
                            for (k = j; k + 1 < q_cnt; k++) begin
                                q_id[k] = q_id[k + 1];
                                q_size[k] = q_size[k + 1];
                                q_time[k] = q_time[k + 1];
                            end
                            q_cnt--;
                            o.placed_count = o.placed_count + 5'd1;
                            break;
                        end
                    end
                end
            end
        end
        o.all_idle = 1'b1;
        for (i = 0; i < p_cnt; i++)
            if (p_busy[i])
                o.all_idle = 1'b0;
        o.free_memory = free_units[15:0];
        o.waiting_count = q_cnt[4:0];
        return o;
    endfunction

    assign pending = expected_rsp_q.size();

    // watch the channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n) begin
            free_units = {1'b0, DefaultMemory};
            for (int i = 0; i < NumParts; i++)
                p_busy[i] = 1'b0;
            p_cnt = 0;
            q_cnt = 0;
            closed = 1'b0;
            fail_count <= 0;
            expected_rsp_q.delete();
        end
        else begin
            if (cfg_we)
                free_units = {1'b0, cfg_wdata};
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, rsp_data);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_rsp_q.pop_front();
                    if (e !== rsp_data) begin
                        $display({"%0t: mismatch expected st=%0d dv=%0d id=%0d pc=%0d",
                                  " fm=%0d wc=%0d idle=%0d"},
                                 $time, e.status, e.done_valid, e.done_id, e.placed_count,
                                 e.free_memory, e.waiting_count, e.all_idle);
                        $display({"%0t:          actual   st=%0d dv=%0d id=%0d pc=%0d",
                                  " fm=%0d wc=%0d idle=%0d"},
                                 $time, rsp_data.status, rsp_data.done_valid, rsp_data.done_id,
                                 rsp_data.placed_count, rsp_data.free_memory,
                                 rsp_data.waiting_count, rsp_data.all_idle);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsp_q.insert(expected_rsp_q.size(), predict_alloc(req_data));
        end
    end
endmodule

// File: test/tb_partition_first_fit_allocator.sv
// testbench top for the partition first-fit allocator: stimulus and verdict
// depends on pffa_pkg, pffa_if, pffa_alloc_checker and the rtl
module tb_partition_first_fit_allocator;
    import pffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          idle_pct = 36;
    int          stall_cnt = 0;
    logic [7:0]  next_id = 8'd0;

    pffa_req_if in_ch();
    pffa_rsp_if out_ch();

    partition_first_fit_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    pffa_alloc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req_data(in_ch.data),
        .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp_data(out_ch.data),
        .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // response side random stall
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= idle_pct);

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // send one request, with a random gap before it
    task automatic send_req(input logic m, input logic [7:0] id,
                            input logic [15:0] sz, input logic [15:0] rt);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= '{mode: m, proc_id: id, proc_size: sz, run_time: rt};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        in_ch.valid <= 1'b0;
        // the block is busy for at least this cycle after intake
        @(posedge clk);
    endtask

    task automatic write_memory(input logic [15:0] v);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // submit with small sizes and run times, sometimes extremes
    task automatic random_submit();
        logic [15:0] sz;
        logic [15:0] rt;
        case ($urandom_range(9))
            0: sz = 16'($urandom);
            1: sz = 16'd0;
            default: sz = 16'($urandom_range(12));
        endcase
        rt = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        next_id = next_id + 8'd1;
        send_req(ModeSubmit, ($urandom_range(3) == 0) ? 8'($urandom) : next_id, sz, rt);
    endtask

    initial
    begin
        logic [15:0] mem_settings[5];
        int n;
        mem_settings = '{16'd40, 16'd0, 16'hFFFF, 16'd20, 16'd100};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default memory, extremes, zero size and time, full queue
        send_req(ModeSubmit, 8'hFF, 16'd0, 16'd0);
        send_req(ModeTick, 8'hA5, 16'hFFFF, 16'hFFFF);
        send_req(ModeSubmit, 8'd1, 16'd30, 16'd2);
        send_req(ModeSubmit, 8'd2, 16'hFFFF, 16'hFFFF);
        send_req(ModeSubmit, 8'd3, 16'd5, 16'd0);
        for (int i = 0; i < 16; i++)
            send_req(ModeSubmit, 8'(10 + i), 16'(i), 16'(i % 3));
        repeat (4) send_req(ModeTick, 8'd0, 16'd0, 16'd0);

        // random phases over several memory sizes
        for (int ph = 0; ph < 5; ph++) begin
            write_memory(ph == 0 ? 16'hFFFF : mem_settings[ph]);
            idle_pct = (ph == 2) ? 0 : 36;
            // occupied partitions free only on ticks; a memory write overwrites the free memory count
            n = 180;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(99) < 55)
                    random_submit();
                else
                    send_req(ModeTick, 8'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/pffa_pkg.sv
hw/rtl/pffa_if.sv
hw/rtl/pffa_cmp.sv
hw/rtl/partition_first_fit_allocator.sv
hw/rtl/pffa_checker.sv
test/pffa_alloc_checker.sv
test/tb_partition_first_fit_allocator.sv
